[sv/srf_pkg.sv]
// ----------------------------------------------------------------------------
// srf_pkg: shared types and constants for the shift/rotate flag unit
// Operation codes, width codes, flag-write codes and the flag bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

   localparam int DataW = 64;

   // operation codes
   localparam logic [2:0] ACT_SHL = 3'd0;
   localparam logic [2:0] ACT_SHR = 3'd1;
   localparam logic [2:0] ACT_SAR = 3'd2;
   localparam logic [2:0] ACT_ROL = 3'd3;
   localparam logic [2:0] ACT_ROR = 3'd4;

   // operand width codes
   localparam logic [1:0] WID_8  = 2'd0;
   localparam logic [1:0] WID_16 = 2'd1;
   localparam logic [1:0] WID_32 = 2'd2;
   localparam logic [1:0] WID_64 = 2'd3;

   // which flags the operation writes
   localparam logic [1:0] FW_NONE  = 2'd0;
   localparam logic [1:0] FW_CO    = 2'd1;
   localparam logic [1:0] FW_ALL   = 2'd2;

   typedef struct packed {
      logic       carry;
      logic       overflow;
      logic       sign;
      logic       zero;
      logic       parity;
      logic [1:0] flags_written;
   } srf_flags_type;

   // most significant bit of a value at the selected width
   function automatic logic top_bit(input logic [DataW-1:0] x, input logic [1:0] wsel);
      logic b;
      case (wsel)
         WID_8:   b = x[7];
         WID_16:  b = x[15];
         WID_32:  b = x[31];
         WID_64:  b = x[63];
         default: b = x[63];
      endcase
      return b;
   endfunction

   // bit just below the most significant bit at the selected width
   function automatic logic next_bit(input logic [DataW-1:0] x, input logic [1:0] wsel);
      logic b;
      case (wsel)
         WID_8:   b = x[6];
         WID_16:  b = x[14];
         WID_32:  b = x[30];
         WID_64:  b = x[62];
         default: b = x[62];
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[sv/srf_core.sv]
// ----------------------------------------------------------------------------
// srf_core: shift/rotate datapath with flag generation
// Single-pass logic: width masking, barrel shift or rotate, flag rules.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_core (
   input  wire logic [2:0]                  action,
   input  wire logic [1:0]                  width_sel,
   input  wire logic [srf_pkg::DataW-1:0]   operand,
   input  wire logic [5:0]                  count,
   output logic      [srf_pkg::DataW-1:0]   result,
   output srf_pkg::srf_flags_type           flags
);
   import srf_pkg::*;

   logic [DataW-1:0]   mask;
   logic [DataW-1:0]   val;
   logic [DataW-1:0]   sval;
   logic [DataW-1:0]   rep;
   logic [DataW-1:0]   t_shl;
   logic [DataW-1:0]   t_shr;
   logic [DataW-1:0]   t_sar;
   logic [DataW-1:0]   res;
   logic [2*DataW-1:0] rot_l;
   logic [2*DataW-1:0] rot_r;
   logic [5:0]         cnt;
   logic [5:0]         cnt_m1;
   logic [5:0]         rot_amt;
   logic               top_v;
   logic               msb_r;

   always_comb begin
      case (width_sel)
         WID_8: begin
            mask    = 64'h0000_0000_0000_00ff;
            cnt     = {1'b0, count[4:0]};
            rot_amt = {3'b000, count[2:0]};
         end
         WID_16: begin
            mask    = 64'h0000_0000_0000_ffff;
            cnt     = {1'b0, count[4:0]};
            rot_amt = {2'b00, count[3:0]};
         end
         WID_32: begin
            mask    = 64'h0000_0000_ffff_ffff;
            cnt     = {1'b0, count[4:0]};
            rot_amt = {1'b0, count[4:0]};
         end
         default: begin
            mask    = 64'hffff_ffff_ffff_ffff;
            cnt     = count;
            rot_amt = count;
         end
      endcase

      val    = operand & mask;
      top_v  = top_bit(val, width_sel);
      sval   = top_v ? (val | ~mask) : val;
      cnt_m1 = cnt - 6'd1;

      // periodic copy of the operand so a 64-bit rotate serves every width
      case (width_sel)
         WID_8:   rep = {8{val[7:0]}};
         WID_16:  rep = {4{val[15:0]}};
         WID_32:  rep = {2{val[31:0]}};
         default: rep = val;
      endcase

      t_shl = val << cnt_m1;
      t_shr = val >> cnt_m1;
      t_sar = DataW'($signed(sval) >>> cnt_m1);
      rot_l = {rep, rep} << rot_amt;
      rot_r = {rep, rep} >> rot_amt;

      res   = val;
      msb_r = 1'b0;
      flags = '0;

      if (cnt != 6'd0) begin
         case (action)
            ACT_SHL: begin
               res                 = (val << cnt) & mask;
               flags.carry         = top_bit(t_shl, width_sel);
               flags.overflow      = (cnt == 6'd1) & (top_bit(res, width_sel) ^ flags.carry);
               flags.flags_written = FW_ALL;
            end
            ACT_SHR: begin
               res                 = val >> cnt;
               flags.carry         = t_shr[0];
               flags.overflow      = (cnt == 6'd1) & top_v;
               flags.flags_written = FW_ALL;
            end
            ACT_SAR: begin
               res                 = DataW'($signed(sval) >>> cnt) & mask;
               flags.carry         = t_sar[0];
               flags.flags_written = FW_ALL;
            end
            ACT_ROL: begin
               res                 = rot_l[2*DataW-1:DataW] & mask;
               msb_r               = top_bit(res, width_sel);
               flags.carry         = res[0];
               flags.overflow      = (cnt == 6'd1) & (msb_r ^ res[0]);
               flags.flags_written = FW_CO;
            end
            ACT_ROR: begin
               res                 = rot_r[DataW-1:0] & mask;
               msb_r               = top_bit(res, width_sel);
               flags.carry         = msb_r;
               flags.overflow      = (cnt == 6'd1) & (msb_r ^ next_bit(res, width_sel));
               flags.flags_written = FW_CO;
            end
            default: begin
               res = val;
            end
         endcase

         if (flags.flags_written == FW_ALL) begin
            flags.sign   = top_bit(res, width_sel);
            flags.zero   = (res == '0);
            flags.parity = ~^res[7:0];
         end
      end

      result = res;
   end

endmodule

`default_nettype wire

[sv/x86_shift_rotate_flags.sv]
// path: a request is held in the input register, then in the result register
// throughput: one request per cycle while rsp_ready is high; the shift/rotate datapath is a single pass
// a stalled result holds its register while the input stage may still take one request
// reset: synchronous, active high; clears both valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
// x86_shift_rotate_flags: x86 shift and rotate unit with flags
// SHL, SHR, SAR, ROL, ROR at 8/16/32/64 bits, returning result and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_shift_rotate_flags (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [2:0]                  req_action,
   input  wire logic [1:0]                  req_width_sel,
   input  wire logic [srf_pkg::DataW-1:0]   req_operand,
   input  wire logic [5:0]                  req_count,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [srf_pkg::DataW-1:0]   rsp_result,
   output logic                             rsp_carry,
   output logic                             rsp_overflow,
   output logic                             rsp_sign,
   output logic                             rsp_zero,
   output logic                             rsp_parity,
   output logic      [1:0]                  rsp_flags_written
);
   import srf_pkg::*;

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [2:0]       in_action_ff;
   logic [1:0]       in_width_ff;
   logic [DataW-1:0] in_operand_ff;
   logic [5:0]       in_count_ff;

   logic             out_valid_ff;
   logic             out_valid_in;
   logic [DataW-1:0] out_result_ff;
   srf_flags_type    out_flags_ff;

   logic [DataW-1:0] core_result;
   srf_flags_type    core_flags;
   logic             out_take;
   logic             in_take;

   srf_core u_core (
      .action    (in_action_ff),
      .width_sel (in_width_ff),
      .operand   (in_operand_ff),
      .count     (in_count_ff),
      .result    (core_result),
      .flags     (core_flags)
   );

   // result register loads a pending input when empty or being drained
   assign out_take     = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready    = ~in_valid_ff | out_take;
   assign in_take      = req_valid & req_ready;
   assign in_valid_in  = in_take | (in_valid_ff & ~out_take);
   assign out_valid_in = out_take | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_action_ff  <= req_action;
         in_width_ff   <= req_width_sel;
         in_operand_ff <= req_operand;
         in_count_ff   <= req_count;
      end
      if (out_take) begin
         out_result_ff <= core_result;
         out_flags_ff  <= core_flags;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result        = out_result_ff;
   assign rsp_carry         = out_flags_ff.carry;
   assign rsp_overflow      = out_flags_ff.overflow;
   assign rsp_sign          = out_flags_ff.sign;
   assign rsp_zero          = out_flags_ff.zero;
   assign rsp_parity        = out_flags_ff.parity;
   assign rsp_flags_written = out_flags_ff.flags_written;

endmodule

`default_nettype wire

[tb/x86_shift_rotate_flags_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_shift_rotate_flags_check: result checker for the shift/rotate flag unit
// Watches both channels, computes the expected result and flags for every
// accepted request, and compares each returned result against the oldest one.
// ----------------------------------------------------------------------------

module x86_shift_rotate_flags_check (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic [2:0]                  req_action,
   input  wire logic [1:0]                  req_width_sel,
   input  wire logic [srf_pkg::DataW-1:0]   req_operand,
   input  wire logic [5:0]                  req_count,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [srf_pkg::DataW-1:0]   rsp_result,
   input  wire logic                        rsp_carry,
   input  wire logic                        rsp_overflow,
   input  wire logic                        rsp_sign,
   input  wire logic                        rsp_zero,
   input  wire logic                        rsp_parity,
   input  wire logic [1:0]                  rsp_flags_written,
   output int                               errors,
   output int                               backlog
);
   import srf_pkg::*;

   typedef struct packed {
      logic [DataW-1:0] result;
      srf_flags_type    flags;
   } shift_outcome_type;

   shift_outcome_type pending_outcomes[$];

   function automatic shift_outcome_type shift_rotate_predict(
      input logic [2:0]       action,
      input logic [1:0]       wsel,
      input logic [DataW-1:0] operand,
      input logic [5:0]       count
   );
      int unsigned       w;
      int unsigned       c;
      int unsigned       r;
      logic [DataW-1:0]  mask;
      logic [DataW-1:0]  v;
      logic [DataW-1:0]  res;
      logic [DataW-1:0]  s;
      logic [DataW-1:0]  fill;
      logic              msb;
      shift_outcome_type o;
      w    = 8 << wsel;
      mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
      v    = operand & mask;
      c    = (wsel == WID_64) ? 32'(count) : 32'(count[4:0]);
      res  = v;
      o    = '0;
      if (c != 0 && action inside {ACT_SHL, ACT_SHR, ACT_SAR}) begin
         case (action)
            ACT_SHL: begin
               res = (v << c) & mask;
               o.flags.carry = (c <= w) ? v[w-c] : 1'b0;
               if (c == 1) o.flags.overflow = res[w-1] ^ o.flags.carry;
            end
            ACT_SHR: begin
               res = v >> c;
               o.flags.carry = v[c-1];
               if (c == 1) o.flags.overflow = v[w-1];
            end
            default: begin
               // sign-extend to 64 bits, then fill the vacated top bits
               s    = v[w-1] ? (v | ~mask) : v;
               fill = v[w-1] ? ~({DataW{1'b1}} >> c) : '0;
               res  = ((s >> c) | fill) & mask;
               o.flags.carry = s[c-1];
            end
         endcase
         o.flags.sign          = res[w-1];
         o.flags.zero          = (res == '0);
         o.flags.parity        = ~^res[7:0];
         o.flags.flags_written = FW_ALL;
      end else if (c != 0 && action inside {ACT_ROL, ACT_ROR}) begin
         r = c & (w - 1);
         if (r != 0) begin
            if (action == ACT_ROL) res = ((v << r) | (v >> (w - r))) & mask;
            else                   res = ((v >> r) | (v << (w - r))) & mask;
         end
         msb = res[w-1];
         if (action == ACT_ROL) begin
            o.flags.carry = res[0];
            if (c == 1) o.flags.overflow = msb ^ res[0];
         end else begin
            o.flags.carry = msb;
            if (c == 1) o.flags.overflow = msb ^ res[w-2];
         end
         o.flags.flags_written = FW_CO;
      end
      o.result = res;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                  input logic [DataW-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      errors = errors + 1;
   endtask

   always @(posedge clock) begin
      shift_outcome_type want;
      if (reset) begin
         pending_outcomes.delete();
         errors  = 0;
         backlog = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result with no request outstanding", rsp_result, '0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_result !== want.result)
                  report_mismatch("result", rsp_result, want.result);
               if (rsp_carry !== want.flags.carry)
                  report_mismatch("carry", rsp_carry, want.flags.carry);
               if (rsp_overflow !== want.flags.overflow)
                  report_mismatch("overflow", rsp_overflow, want.flags.overflow);
               if (rsp_sign !== want.flags.sign)
                  report_mismatch("sign", rsp_sign, want.flags.sign);
               if (rsp_zero !== want.flags.zero)
                  report_mismatch("zero", rsp_zero, want.flags.zero);
               if (rsp_parity !== want.flags.parity)
                  report_mismatch("parity", rsp_parity, want.flags.parity);
               if (rsp_flags_written !== want.flags.flags_written)
                  report_mismatch("flags_written", rsp_flags_written,
                                  want.flags.flags_written);
            end
         end
         if (req_valid && req_ready)
            pending_outcomes.push_back(shift_rotate_predict(req_action, req_width_sel,
                                                            req_operand, req_count));
         backlog = pending_outcomes.size();
      end
   end

endmodule

[tb/x86_shift_rotate_flags_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_shift_rotate_flags_test: testbench top for the shift/rotate flag unit
// Drives directed corner requests, then random shifts and rotates with random
// gaps and back-pressure; the checker beside the block scores every result.
// ----------------------------------------------------------------------------

module x86_shift_rotate_flags_test;
   import srf_pkg::*;

   // action codes the block does not implement
   localparam logic [2:0] ACT_RSVD5 = 3'd5;
   localparam logic [2:0] ACT_RSVD6 = 3'd6;
   localparam logic [2:0] ACT_RSVD7 = 3'd7;

   localparam int RandomRequests = 1900;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [2:0]       req_action;
   logic [1:0]       req_width_sel;
   logic [DataW-1:0] req_operand;
   logic [5:0]       req_count;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [DataW-1:0] rsp_result;
   logic             rsp_carry;
   logic             rsp_overflow;
   logic             rsp_sign;
   logic             rsp_zero;
   logic             rsp_parity;
   logic [1:0]       rsp_flags_written;
   int               errors;
   int               backlog;
   logic             quiet;

   x86_shift_rotate_flags i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_width_sel     (req_width_sel),
      .req_operand       (req_operand),
      .req_count         (req_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result        (rsp_result),
      .rsp_carry         (rsp_carry),
      .rsp_overflow      (rsp_overflow),
      .rsp_sign          (rsp_sign),
      .rsp_zero          (rsp_zero),
      .rsp_parity        (rsp_parity),
      .rsp_flags_written (rsp_flags_written)
   );

   x86_shift_rotate_flags_check i_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("x86_shift_rotate_flags_test: done, errors");
      $finish;
   end

   // result side: random stall after each accepted result
   initial begin
      int hold;
      hold = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            hold = quiet ? 0 : $urandom_range(0, 3);
            if (hold != 0) rsp_ready <= 1'b0;
         end else if (!rsp_ready) begin
            hold = hold - 1;
            if (hold <= 0) rsp_ready <= 1'b1;
         end
      end
   end

   task automatic issue_shift(input logic [2:0] action, input logic [1:0] wsel,
                              input logic [DataW-1:0] operand, input logic [5:0] count);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_action    <= action;
      req_width_sel <= wsel;
      req_operand   <= operand;
      req_count     <= count;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [DataW-1:0] random_operand();
      logic [DataW-1:0] bit_mask;
      bit_mask = 64'd1 << $urandom_range(0, 63);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return bit_mask;
         3:       return ~bit_mask;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [2:0]       action;
      logic [1:0]       wsel;
      logic [5:0]       count;
      quiet         = 1'b0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_action    <= ACT_SHL;
      req_width_sel <= WID_8;
      req_operand   <= '0;
      req_count     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single-bit shifts and rotates, overflow rules
      issue_shift(ACT_SHL, WID_8, 64'h80, 6'd1);
      issue_shift(ACT_SHR, WID_8, 64'h81, 6'd1);
      issue_shift(ACT_SAR, WID_8, 64'h80, 6'd1);
      issue_shift(ACT_ROL, WID_8, 64'h80, 6'd1);
      issue_shift(ACT_ROR, WID_16, 64'h0001, 6'd1);
      issue_shift(ACT_SHL, WID_64, 64'h4000_0000_0000_0000, 6'd1);
      // unimplemented actions pass the operand through
      issue_shift(ACT_RSVD5, WID_16, '1, 6'd3);
      issue_shift(ACT_RSVD6, WID_32, 64'h1234_5678_9abc_def0, 6'd1);
      issue_shift(ACT_RSVD7, WID_64, '1, 6'd63);
      // zero count, also after masking; upper operand bits ignored
      issue_shift(ACT_SHL, WID_64, '1, 6'd0);
      issue_shift(ACT_ROR, WID_32, 64'hffff_ffff_8000_0001, 6'd32);
      // counts at and beyond the width
      issue_shift(ACT_SHL, WID_8, 64'h01, 6'd8);
      issue_shift(ACT_SHL, WID_16, 64'hffff, 6'd20);
      issue_shift(ACT_SHR, WID_16, 64'h8000, 6'd17);
      issue_shift(ACT_SAR, WID_8, 64'h80, 6'd20);
      issue_shift(ACT_SAR, WID_16, 64'h8000, 6'd31);
      issue_shift(ACT_SAR, WID_64, 64'h8000_0000_0000_0000, 6'd63);
      issue_shift(ACT_SHR, WID_64, '1, 6'd63);
      issue_shift(ACT_SAR, WID_32, 64'h0, 6'd31);
      issue_shift(ACT_SHR, WID_32, 64'h7fff_ffff, 6'd5);
      // rotates by a multiple of the width (carry still written) and by large counts
      issue_shift(ACT_ROL, WID_8, 64'ha5, 6'd16);
      issue_shift(ACT_ROL, WID_64, 64'h8000_0000_0000_0001, 6'd63);
      issue_shift(ACT_ROR, WID_8, 64'h01, 6'd9);

      for (int n = 0; n < RandomRequests; n++) begin
         // occasional stretches with no gaps on either side
         if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 15) == 0) action = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
         else                            action = 3'($urandom_range(ACT_SHL, ACT_ROR));
         wsel = 2'($urandom_range(WID_8, WID_64));
         case ($urandom_range(0, 3))
            0:       count = 6'($urandom_range(0, 2));
            1:       count = 6'((8 << wsel) - 1 + $urandom_range(0, 2));
            default: count = 6'($urandom_range(0, 63));
         endcase
         issue_shift(action, wsel, random_operand(), count);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (errors == 0 && backlog == 0) begin
         $display("x86_shift_rotate_flags_test: done, clean");
      end else begin
         $display("x86_shift_rotate_flags_test: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/srf_pkg.sv
sv/srf_core.sv
sv/x86_shift_rotate_flags.sv
tb/x86_shift_rotate_flags_check.sv
tb/x86_shift_rotate_flags_test.sv
